/* rtl/smac_pkg.sv */
// smac_pkg: shared types, constants and command structs for the moving
// average crossover block; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package smac_pkg;

    localparam int MAX_WINDOW_DEF    = 64;
    localparam int HISTORY_DEPTH_DEF = 64;
    localparam int LEN_W   = 7;
    localparam int RPT_W   = 6;
    localparam int PRICE_W = 32;

    localparam logic CFG_WINDOW_LENGTH   = 1'b0;
    localparam logic CFG_REPEAT_INTERVAL = 1'b1;

    typedef struct packed {
        logic [PRICE_W-1:0] open_price;
        logic [PRICE_W-1:0] close_price;
    } in_item_t;

    typedef struct packed {
        logic               average_valid;
        logic [PRICE_W-1:0] average;
        logic               buy_flag;
        logic               sell_flag;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RDOLD,
        ST_SUM,
        ST_DIV,
        ST_STORE,
        ST_RDPREV,
        ST_SCAN,
        ST_SCANCHK,
        ST_DONE,
        ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic rd_old;
        logic sum;
        logic div_start;
        logic div_step;
        logic store;
        logic rd_prev;
        logic scan_rd;
        logic scan_chk;
        logic finish;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic div_done;
        logic have_two;
        logic scan_done;
    } sts_t;

endpackage
`default_nettype wire

/* rtl/smac_ctrl.sv */
// smac_ctrl: sequencer for one item at a time
// depends on smac_pkg
`timescale 1ns / 1ps
`default_nettype none
module smac_ctrl (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_fire,
    input  wire                out_fire,
    input  wire smac_pkg::sts_t sts,
    output smac_pkg::cmd_t     cmd,
    output logic               busy,
    output logic               out_valid
);
    import smac_pkg::*;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (in_fire)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RDOLD;
                end
            end
            ST_RDOLD:
            begin
                cmd.rd_old = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (!sts.full)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_STORE;
                end
            end
            ST_STORE:
            begin
                if (!sts.div_done)
                    cmd.div_step = 1'b1;
                else
                begin
                    cmd.store  = 1'b1;
                    state_next = ST_RDPREV;
                end
            end
            ST_RDPREV:
            begin
                cmd.rd_prev = 1'b1;
                state_next  = sts.have_two ? ST_SCAN : ST_DONE;
            end
            ST_SCAN:
            begin
                if (sts.scan_done)
                    state_next = ST_DONE;
                else
                begin
                    cmd.scan_rd = 1'b1;
                    state_next  = ST_SCANCHK;
                end
            end
            ST_SCANCHK:
            begin
                cmd.scan_chk = 1'b1;
                state_next   = ST_SCAN;
            end
            ST_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_fire)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

/* rtl/smac_dp.sv */
// smac_dp: price window, running sum, serial divider, average history
// and repeat scan; depends on smac_pkg
`timescale 1ns / 1ps
`default_nettype none
module smac_dp #(
    parameter int MAX_WINDOW    = smac_pkg::MAX_WINDOW_DEF,
    parameter int HISTORY_DEPTH = smac_pkg::HISTORY_DEPTH_DEF
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire smac_pkg::cmd_t    cmd,
    input  wire smac_pkg::in_item_t in_item,
    input  wire                    cfg_len_we,
    input  wire [smac_pkg::LEN_W-1:0] cfg_len,
    input  wire                    cfg_rpt_we,
    input  wire [smac_pkg::RPT_W-1:0] cfg_rpt,
    output smac_pkg::sts_t         sts,
    output smac_pkg::out_item_t    out_item
);
    import smac_pkg::*;

    localparam int WA = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int HA = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int WC = $clog2(MAX_WINDOW + 1);
    localparam int HC = $clog2(HISTORY_DEPTH + 1);
    localparam int SW = PRICE_W + WC;
    localparam int DC = $clog2(SW + 1);

    logic [PRICE_W-1:0] win_mem [MAX_WINDOW];
    logic [PRICE_W-1:0] hist_mem [HISTORY_DEPTH];

    logic [WC-1:0]      len_reg;
    logic [RPT_W-1:0]   rpt_reg;
    logic [WA-1:0]      wpos_reg;
    logic [WC-1:0]      pcnt_reg;
    logic [SW-1:0]      sum_reg;
    logic [HA-1:0]      hpos_reg;
    logic [HC-1:0]      acnt_reg;
    logic [PRICE_W-1:0] lbuy_reg, lsell_reg;
    logic [PRICE_W-1:0] open_reg, close_reg;
    logic [PRICE_W-1:0] wrd_reg, hrd_reg, prev_reg;
    logic               evict_reg, full_reg;
    logic [SW-1:0]      quo_reg;
    logic [WC:0]        rem_reg;
    logic [DC-1:0]      dcnt_reg;
    logic [HC-1:0]      scnt_reg, span_reg;
    logic [HA-1:0]      sidx_reg;
    logic               brep_reg, srep_reg;
    out_item_t          out_reg;

    // clamped length and derived values
    logic [WC-1:0]      len_cl;
    logic [WC:0]        rem_sh, rem_sub;
    logic [WA-1:0]      old_idx;
    logic [HA-1:0]      prev_idx;
    logic [HC-1:0]      acnt_inc;
    logic [HC-1:0]      span_full;
    logic               buy_c, sell_c;

    always_comb
    begin
        if (cfg_len == '0)
            len_cl = WC'(1);
        else if (32'(cfg_len) > 32'(MAX_WINDOW))
            len_cl = WC'(MAX_WINDOW);
        else
            len_cl = WC'(cfg_len);
        old_idx   = (32'(wpos_reg) >= 32'(len_reg))
                    ? WA'(32'(wpos_reg) - 32'(len_reg))
                    : WA'(32'(wpos_reg) + 32'(MAX_WINDOW) - 32'(len_reg));
        prev_idx  = (32'(hpos_reg) >= 32'd2)
                    ? HA'(32'(hpos_reg) - 32'd2)
                    : HA'(32'(hpos_reg) + 32'(HISTORY_DEPTH) - 32'd2);
        acnt_inc  = (32'(acnt_reg) < 32'(HISTORY_DEPTH)) ? acnt_reg + 1'b1 : acnt_reg;
        rem_sh    = {rem_reg[WC-1:0], quo_reg[SW-1]};
        rem_sub   = rem_sh - (WC+1)'(len_reg);
        span_full = (32'(rpt_reg) + 32'd1 > 32'(acnt_inc)) ? acnt_inc
                                                          : HC'(32'(rpt_reg) + 32'd1);
        buy_c  = (quo_reg[PRICE_W-1:0] > open_reg) && (quo_reg[PRICE_W-1:0] < close_reg)
                 && (prev_reg < quo_reg[PRICE_W-1:0]) && !brep_reg;
        sell_c = (quo_reg[PRICE_W-1:0] < open_reg) && (quo_reg[PRICE_W-1:0] > close_reg)
                 && (prev_reg > quo_reg[PRICE_W-1:0]) && !srep_reg;
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.sum)
            win_mem[wpos_reg] <= close_reg;
        if (cmd.rd_old)
            wrd_reg <= win_mem[old_idx];
        if (cmd.store)
            hist_mem[hpos_reg] <= quo_reg[PRICE_W-1:0];
        if (cmd.rd_prev)
            prev_reg <= hist_mem[prev_idx];
        else if (cmd.scan_rd)
            hrd_reg <= hist_mem[sidx_reg];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= WC'(20 > MAX_WINDOW ? MAX_WINDOW : 20);
            rpt_reg   <= RPT_W'(3);
            wpos_reg  <= '0;
            pcnt_reg  <= '0;
            sum_reg   <= '0;
            hpos_reg  <= '0;
            acnt_reg  <= '0;
            lbuy_reg  <= '0;
            lsell_reg <= '0;
        end
        else
        begin
            if (cfg_len_we)
            begin
                len_reg  <= len_cl;
                wpos_reg <= '0;
                pcnt_reg <= '0;
                sum_reg  <= '0;
                hpos_reg <= '0;
                acnt_reg <= '0;
            end
            if (cfg_rpt_we)
                rpt_reg <= cfg_rpt;
            if (cmd.sum)
            begin
                wpos_reg <= (32'(wpos_reg) == 32'(MAX_WINDOW) - 32'd1) ? '0
                                                                       : wpos_reg + 1'b1;
                sum_reg  <= sum_reg - (evict_reg ? SW'(wrd_reg) : '0) + SW'(close_reg);
                if (!evict_reg)
                    pcnt_reg <= pcnt_reg + 1'b1;
            end
            if (cmd.store)
            begin
                hpos_reg <= (32'(hpos_reg) == 32'(HISTORY_DEPTH) - 32'd1) ? '0
                                                                          : hpos_reg + 1'b1;
                acnt_reg <= acnt_inc;
            end
            if (cmd.finish && full_reg && (acnt_reg >= HC'(2)) && buy_c)
                lbuy_reg <= quo_reg[PRICE_W-1:0];
            if (cmd.finish && full_reg && (acnt_reg >= HC'(2)) && sell_c)
                lsell_reg <= quo_reg[PRICE_W-1:0];
        end
    end

    // item datapath
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            open_reg  <= in_item.open_price;
            close_reg <= in_item.close_price;
            evict_reg <= (pcnt_reg >= len_reg);
            brep_reg  <= 1'b0;
            srep_reg  <= 1'b0;
        end
        if (cmd.sum)
            full_reg <= evict_reg || (pcnt_reg + 1'b1 >= len_reg);
        // restoring divider, one quotient bit per cycle
        if (cmd.div_start)
        begin
            quo_reg  <= sum_reg;
            rem_reg  <= '0;
            dcnt_reg <= DC'(SW);
        end
        else if (cmd.div_step)
        begin
            dcnt_reg <= dcnt_reg - 1'b1;
            if (!rem_sub[WC])
            begin
                rem_reg <= rem_sub;
                quo_reg <= {quo_reg[SW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[SW-2:0], 1'b0};
            end
        end
        if (cmd.store)
        begin
            span_reg <= span_full;
            scnt_reg <= '0;
            sidx_reg <= hpos_reg;
        end
        // scan newest first; entry just stored is compared from quotient
        if (cmd.scan_rd)
        begin
            sidx_reg <= (sidx_reg == '0) ? HA'(HISTORY_DEPTH - 1) : sidx_reg - 1'b1;
        end
        if (cmd.scan_chk)
        begin
            scnt_reg <= scnt_reg + 1'b1;
            if (scnt_reg == '0)
            begin
                if (quo_reg[PRICE_W-1:0] == lbuy_reg) brep_reg <= 1'b1;
                if (quo_reg[PRICE_W-1:0] == lsell_reg) srep_reg <= 1'b1;
            end
            else
            begin
                if (hrd_reg == lbuy_reg) brep_reg <= 1'b1;
                if (hrd_reg == lsell_reg) srep_reg <= 1'b1;
            end
        end
        if (cmd.finish)
        begin
            out_reg.average_valid <= full_reg;
            out_reg.average       <= full_reg ? quo_reg[PRICE_W-1:0] : '0;
            out_reg.buy_flag      <= full_reg && (acnt_reg >= HC'(2)) && buy_c;
            out_reg.sell_flag     <= full_reg && (acnt_reg >= HC'(2)) && sell_c;
        end
    end

    assign sts.full      = full_reg;
    assign sts.div_done  = (dcnt_reg == '0);
    assign sts.have_two  = (acnt_reg >= HC'(2));
    assign sts.scan_done = (scnt_reg >= span_reg);
    assign out_item      = out_reg;
endmodule
`default_nettype wire

/* rtl/sma_crossing_signal_top.sv */
// Moving average crossover signal generator. One candle per item; one
// result per item, and the next candle is taken only after the result has
// left. While the window fills, an item is loaded, the oldest price read and
// the sum updated before the result is given. After that the same setup
// is followed by a bit-serial divide by window length and a store, then a
// search of the stored averages (up to repeat_interval+1, at most 64) for
// a repeated crossing level. The window and history memories are
// single-ported, one access a cycle.
// depends on smac_pkg, smac_ctrl, smac_dp
`timescale 1ns / 1ps
`default_nettype none
module sma_crossing_signal_top #(
    parameter int MAX_WINDOW    = smac_pkg::MAX_WINDOW_DEF,
    parameter int HISTORY_DEPTH = smac_pkg::HISTORY_DEPTH_DEF
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      in_valid,
    output logic                     in_stall,
    input  wire smac_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire                      out_stall,
    output smac_pkg::out_item_t      out_data,
    input  wire                      cfg_valid,
    output logic                     cfg_ready,
    input  wire                      cfg_index,
    input  wire [31:0]               cfg_data
);
    import smac_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic busy;
    logic in_fire, out_fire, cfg_fire;

    assign in_stall  = busy;
    assign in_fire   = in_valid && !busy;
    assign out_fire  = out_valid && !out_stall;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid;

    smac_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .out_fire  (out_fire),
        .sts       (sts),
        .cmd       (cmd),
        .busy      (busy),
        .out_valid (out_valid)
    );

    smac_dp #(
        .MAX_WINDOW    (MAX_WINDOW),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .in_item    (in_data),
        .cfg_len_we (cfg_fire && cfg_index == CFG_WINDOW_LENGTH),
        .cfg_len    (cfg_data[LEN_W-1:0]),
        .cfg_rpt_we (cfg_fire && cfg_index == CFG_REPEAT_INTERVAL),
        .cfg_rpt    (cfg_data[RPT_W-1:0]),
        .sts        (sts),
        .out_item   (out_data)
    );
endmodule
`default_nettype wire
